[hdl/focal_point_phase_drive_macros.svh]
// Assertion macros shared by the checker of the focal point phase drive.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef FOCAL_POINT_PHASE_DRIVE_MACROS_SVH
`define FOCAL_POINT_PHASE_DRIVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/fcp_pkg.sv]
// Shared widths, constants and types of the focal point phase drive.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package fcp_pkg;

	// coordinate and distance arithmetic
	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * COORD_W + 1;
	localparam int SUM_W   = 2 * COORD_W + 2;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 3;

	// wavelength and phase
	localparam int WL_W    = 16;
	localparam int PH_W    = 8;
	localparam int QP_W    = PH_W + 1;
	localparam int NUM_W   = WL_W + QP_W;
	localparam int DWORD_W = 16;
	localparam logic [WL_W-1:0]  WL_RESET    = 16'd2176;
	localparam logic [PH_W-1:0]  AMPLITUDE   = 8'hFF;
	localparam logic [PH_W-1:0]  PHASE_FULL  = 8'd255;
	localparam logic [QP_W-1:0]  PHASE_SCALE = 9'd510;

	// transducer addressing
	localparam int IDX_W          = 14;
	localparam int DEV_W          = 6;
	localparam int SLOT_W         = 8;
	localparam int TPU_W          = 11;
	localparam int TRANS_PER_UNIT = 249;
	localparam int MAX_DEVICES    = 64;
	localparam int RECIP_SH       = IDX_W + 10;
	localparam int RECIP_M        = (2 ** RECIP_SH) / TRANS_PER_UNIT;
	localparam int PROD_W         = IDX_W + RECIP_SH + 1;

	// configuration port
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCUS_X    = 2'd0,
		CFG_FOCUS_Y    = 2'd1,
		CFG_FOCUS_Z    = 2'd2,
		CFG_WAVELENGTH = 2'd3
	} cfg_reg_t;

	// device and slot travel alongside the distance math
	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [SLOT_W-1:0] slot;
	} tag_t;

endpackage

`default_nettype wire

[hdl/fcp_sqdist.sv]
// Squared distance to the focal point and device/slot split of the index.
// Depends on fcp_pkg; three register stages under a common advance enable.
`default_nettype none

module fcp_sqdist import fcp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_v,
	input  wire logic [IDX_W-1:0]         idx,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic signed [COORD_W-1:0] pos_z,
	input  wire logic signed [COORD_W-1:0] focus_x,
	input  wire logic signed [COORD_W-1:0] focus_y,
	input  wire logic signed [COORD_W-1:0] focus_z,
	output logic                          out_v,
	output logic [SUM_W-1:0]              sum,
	output tag_t                          tag
);

	logic                     v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [PROD_W-1:0]        prod_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [IDX_W:0]           r_s2;
	logic [IDX_W-1:0]         q_s2;
	logic [SUM_W-1:0]         sum_s3;
	tag_t                     tag_s3;

	logic [DIFF_W-1:0]        mx, my, mz;
	logic [IDX_W-1:0]         q_est;
	logic [IDX_W+TPU_W-1:0]   qt;
	logic [IDX_W-1:0]         q_fix;
	logic [IDX_W:0]           r_fix;

	// magnitudes of the differences and the reciprocal quotient estimate
	always_comb begin
		mx = (dx_s1 < 0) ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		my = (dy_s1 < 0) ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		mz = (dz_s1 < 0) ? DIFF_W'(-dz_s1) : DIFF_W'(dz_s1);
		q_est = prod_s1[RECIP_SH +: IDX_W];
		qt = (IDX_W+TPU_W)'(q_est) * (IDX_W+TPU_W)'(TRANS_PER_UNIT);
	end

	// correct the reciprocal quotient by one step
	always_comb begin
		if (r_s2 >= (IDX_W+1)'(TRANS_PER_UNIT)) begin
			q_fix = q_s2 + 1'b1;
			r_fix = r_s2 - (IDX_W+1)'(TRANS_PER_UNIT);
		end else begin
			q_fix = q_s2;
			r_fix = r_s2;
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DIFF_W'(pos_x) - DIFF_W'(focus_x);
			dy_s1   <= DIFF_W'(pos_y) - DIFF_W'(focus_y);
			dz_s1   <= DIFF_W'(pos_z) - DIFF_W'(focus_z);
			prod_s1 <= PROD_W'(idx) * PROD_W'(RECIP_M);
			idx_s1  <= idx;

			sqx_s2 <= SQ_W'(mx) * SQ_W'(mx);
			sqy_s2 <= SQ_W'(my) * SQ_W'(my);
			sqz_s2 <= SQ_W'(mz) * SQ_W'(mz);
			q_s2   <= q_est;
			r_s2   <= {1'b0, idx_s1} - {1'b0, qt[IDX_W-1:0]};

			sum_s3      <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
			tag_s3.dev  <= DEV_W'(q_fix % MAX_DEVICES);
			tag_s3.slot <= r_fix[SLOT_W-1:0];
		end
	end

	assign out_v = v_s3;
	assign sum   = sum_s3;
	assign tag   = tag_s3;

endmodule

`default_nettype wire

[hdl/fcp_isqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on fcp_pkg; gives the floor root and the remainder.
`default_nettype none

module fcp_isqrt import fcp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [SUM_W-1:0]  rad,
	input  tag_t                   in_tag,
	output logic                   out_v,
	output logic [ROOT_W-1:0]      root,
	output logic [REM_W-1:0]       rem,
	output tag_t                   tag
);

	localparam int N = ROOT_W;

	logic              v_s    [0:N];
	logic [SUM_W-1:0]  rad_s  [0:N];
	logic [ROOT_W-1:0] root_s [0:N];
	logic [REM_W-1:0]  rem_s  [0:N];
	tag_t              tag_s  [0:N];

	assign v_s[0]    = in_v;
	assign rad_s[0]  = rad;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign tag_s[0]  = in_tag;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		// bring down two radicand bits and try the next root bit
		always_comb begin
			rem_sh = {rem_s[k][REM_W-3:0], rad_s[k][SUM_W-1 -: 2]};
			trial  = {1'b0, root_s[k], 2'b01};
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][SUM_W-3:0], 2'b00};
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_v = v_s[N];
	assign root  = root_s[N];
	assign rem   = rem_s[N];
	assign tag   = tag_s[N];

endmodule

`default_nettype wire

[hdl/fcp_phase.sv]
// Rounds the root, reduces it modulo the wavelength and scales it to a phase.
// Depends on fcp_pkg; bit-per-stage restoring modulo and division pipelines.
`default_nettype none

module fcp_phase import fcp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_v,
	input  wire logic [ROOT_W-1:0]  root,
	input  wire logic [REM_W-1:0]   rem,
	input  tag_t                    in_tag,
	input  wire logic [WL_W-1:0]    wl,
	output logic                    out_v,
	output logic [DEV_W-1:0]        dev,
	output logic [SLOT_W-1:0]       slot,
	output logic [DWORD_W-1:0]      drive
);

	localparam int MN = ROOT_W;
	localparam int DN = QP_W;

	// rounding stage
	logic              v_r_s1;
	logic [ROOT_W-1:0] dist_r_s1;
	tag_t              tag_r_s1;

	// modulo chain
	logic              mv_s   [0:MN];
	logic [ROOT_W-1:0] md_s   [0:MN];
	logic [WL_W-1:0]   mr_s   [0:MN];
	tag_t              mtag_s [0:MN];

	// numerator stage
	logic              v_n_s1;
	logic [NUM_W-1:0]  num_n_s1;
	tag_t              tag_n_s1;

	// division chain
	logic              dv_s   [0:DN];
	logic [NUM_W-1:0]  dn_s   [0:DN];
	logic [QP_W-1:0]   dq_s   [0:DN];
	tag_t              dtag_s [0:DN];

	// output register
	logic              v_o_s1;
	logic [DEV_W-1:0]  dev_o_s1;
	logic [SLOT_W-1:0] slot_o_s1;
	logic [PH_W-1:0]   ph_o_s1;

	logic [PH_W-1:0]   ph_sel;

	// round the root to nearest and prepare the numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r_s1 <= 1'b0;
			v_n_s1 <= 1'b0;
			v_o_s1 <= 1'b0;
		end else if (en) begin
			v_r_s1 <= in_v;
			v_n_s1 <= mv_s[MN];
			v_o_s1 <= dv_s[DN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_r_s1 <= root + ROOT_W'(rem > REM_W'(root));
			tag_r_s1  <= in_tag;
			num_n_s1  <= NUM_W'(PHASE_SCALE) * NUM_W'(wl - mr_s[MN]) + NUM_W'(wl);
			tag_n_s1  <= mtag_s[MN];
		end
	end

	assign mv_s[0]   = v_r_s1;
	assign md_s[0]   = dist_r_s1;
	assign mr_s[0]   = '0;
	assign mtag_s[0] = tag_r_s1;

	for (genvar k = 0; k < MN; k++) begin : g_mod
		logic [WL_W:0] r_sh;
		logic          ge;

		// shift in one distance bit and drop one wavelength if it fits
		always_comb begin
			r_sh = {mr_s[k], md_s[k][ROOT_W-1]};
			ge   = (r_sh >= {1'b0, wl});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s[k+1] <= 1'b0;
			end else if (en) begin
				mv_s[k+1] <= mv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				md_s[k+1]   <= {md_s[k][ROOT_W-2:0], 1'b0};
				mr_s[k+1]   <= ge ? WL_W'(r_sh - {1'b0, wl}) : WL_W'(r_sh);
				mtag_s[k+1] <= mtag_s[k];
			end
		end
	end

	assign dv_s[0]   = v_n_s1;
	assign dn_s[0]   = num_n_s1;
	assign dq_s[0]   = '0;
	assign dtag_s[0] = tag_n_s1;

	for (genvar j = 0; j < DN; j++) begin : g_div
		logic [NUM_W-1:0] den_sh;
		logic             ge;

		// compare against twice the wavelength at this quotient weight
		always_comb begin
			den_sh = NUM_W'({wl, 1'b0}) << (DN - 1 - j);
			ge     = (dn_s[j] >= den_sh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_s[j+1] <= dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dn_s[j+1]   <= ge ? (dn_s[j] - den_sh) : dn_s[j];
				dq_s[j+1]   <= {dq_s[j][QP_W-2:0], ge};
				dtag_s[j+1] <= dtag_s[j];
			end
		end
	end

	// zero wavelength or overflow saturates to full phase
	always_comb begin
		if (wl == '0 || dq_s[DN][QP_W-1]) begin
			ph_sel = PHASE_FULL;
		end else begin
			ph_sel = dq_s[DN][PH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dev_o_s1  <= dtag_s[DN].dev;
			slot_o_s1 <= dtag_s[DN].slot;
			ph_o_s1   <= ph_sel;
		end
	end

	assign out_v = v_o_s1;
	assign dev   = dev_o_s1;
	assign slot  = slot_o_s1;
	assign drive = {AMPLITUDE, ph_o_s1};

endmodule

`default_nettype wire

[hdl/focal_point_phase_drive.sv]
// Throughput: one request per cycle unless the output stalls; the square root,
// modulo and phase division are bit-per-stage pipelines, so a stage can take a new request as soon as it advances.
// A stalled output freezes the whole pipeline; in_stall follows it.
// Reset clears valid bits and loads focus 0,0,0 and wavelength 2176.
`default_nettype none

module focal_point_phase_drive import fcp_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [IDX_W-1:0]          trans_index,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic signed [COORD_W-1:0] pos_z,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [DEV_W-1:0]               device_index,
	output logic [SLOT_W-1:0]              slot_index,
	output logic [DWORD_W-1:0]             drive_word
);

	logic signed [COORD_W-1:0] focus_x_q, focus_y_q, focus_z_q;
	logic [WL_W-1:0]           wl_q;

	logic              en;
	logic              sq_v, rt_v;
	logic [SUM_W-1:0]  sq_sum;
	tag_t              sq_tag, rt_tag;
	logic [ROOT_W-1:0] rt_root;
	logic [REM_W-1:0]  rt_rem;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_x_q <= '0;
			focus_y_q <= '0;
			focus_z_q <= '0;
			wl_q      <= WL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FOCUS_X:    focus_x_q <= cfg_data;
				CFG_FOCUS_Y:    focus_y_q <= cfg_data;
				CFG_FOCUS_Z:    focus_z_q <= cfg_data;
				CFG_WAVELENGTH: wl_q      <= cfg_data[WL_W-1:0];
			endcase
		end
	end

	// hold everything while a finished result waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	fcp_sqdist u_sqdist (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (in_valid),
		.idx     (trans_index),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.pos_z   (pos_z),
		.focus_x (focus_x_q),
		.focus_y (focus_y_q),
		.focus_z (focus_z_q),
		.out_v   (sq_v),
		.sum     (sq_sum),
		.tag     (sq_tag)
	);

	fcp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (sq_v),
		.rad    (sq_sum),
		.in_tag (sq_tag),
		.out_v  (rt_v),
		.root   (rt_root),
		.rem    (rt_rem),
		.tag    (rt_tag)
	);

	fcp_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (rt_v),
		.root   (rt_root),
		.rem    (rt_rem),
		.in_tag (rt_tag),
		.wl     (wl_q),
		.out_v  (out_valid),
		.dev    (device_index),
		.slot   (slot_index),
		.drive  (drive_word)
	);

endmodule

`default_nettype wire

[hdl/fcp_checker.sv]
// Port-level checks of the focal point phase drive, bound to its top level.
// Depends on fcp_pkg and the assertion macros header.
`default_nettype none

`include "focal_point_phase_drive_macros.svh"

module fcp_checker import fcp_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [SLOT_W-1:0]  slot_index,
	input wire logic [DWORD_W-1:0] drive_word
);

	// a stalled result must stay offered
	`FCP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

	// input backpressure comes only from a waiting result
	`FCP_ASSERT_IMPLY(a_stall_src, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall), "input stall does not track output")

	// amplitude byte is always full
	`FCP_ASSERT_IMPLY(a_amp, clk, arst_n, out_valid, drive_word[15:8] == AMPLITUDE, "amplitude byte wrong")

	// slot lies inside one device
	`FCP_ASSERT_IMPLY(a_slot, clk, arst_n, out_valid, slot_index < TRANS_PER_UNIT, "slot index out of range")

endmodule

bind focal_point_phase_drive fcp_checker u_fcp_checker (.*);

`default_nettype wire
